// ===== hdl/assert_macros.svh =====
// assertion macros shared by the stencil sweep rtl
// no dependencies; included by the files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define DSS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define DSS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/dss_pkg.sv =====
// shared constants and types of the diffusion stencil sweep
// no dependencies; used by the interfaces, the line store and the top level
package dss_pkg;

   // default sizing
   localparam int DEF_MAX_SIDE   = 1024;
   localparam int DEF_VALUE_BITS = 32;
   localparam int MIN_SIDE       = 3;

   // register widths and reset values
   localparam int GRID_SIDE_W = 11;
   localparam int COEFF_W     = 15;
   localparam int CSR_DATA_W  = 15;
   localparam int CSR_INDEX_W = 2;
   localparam logic [GRID_SIDE_W-1:0] GRID_SIDE_RST = 11'd1024;
   localparam logic [COEFF_W-1:0]     COEFF_RST     = 15'd4096;

   // fixed point of the coefficient and the rounding offset
   localparam int FRAC_BITS  = 16;
   localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);

   // register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GRID_SIDE  = 2'd0,
      CSR_DIFF_COEFF = 2'd1
   } csr_index_type;

   // input item kinds
   typedef enum logic {
      KIND_VALUE = 1'b0,
      KIND_FLUSH = 1'b1
   } item_kind_type;

   // line store strobes
   typedef struct packed {
      logic rd_en;
      logic wr_a_en;
      logic wr_b_en;
   } ls_ctl_type;

endpackage

// ===== hdl/dss_req_if.sv =====
// request channel of the stencil sweep: item kind and old grid value
// depends on dss_pkg for the default value width
interface dss_req_if import dss_pkg::*; #(
   parameter int VALUE_BITS = DEF_VALUE_BITS
);
   logic                         valid;
   logic                         ready;
   logic                         kind;
   logic signed [VALUE_BITS-1:0] cell_value;

   modport source (output valid, output kind, output cell_value, input ready);
   modport sink   (input valid, input kind, input cell_value, output ready);
endinterface

// ===== hdl/dss_rsp_if.sv =====
// result channel of the stencil sweep: new grid value and end-of-sweep flag
// depends on dss_pkg for the default value width
interface dss_rsp_if import dss_pkg::*; #(
   parameter int VALUE_BITS = DEF_VALUE_BITS
);
   logic                         valid;
   logic                         ready;
   logic signed [VALUE_BITS-1:0] new_value;
   logic                         sweep_end;

   modport source (output valid, output new_value, output sweep_end, input ready);
   modport sink   (input valid, input new_value, input sweep_end, output ready);
endinterface

// ===== hdl/dss_line_store.sv =====
// two row buffers indexed by column: a holds the previous row, b the one before
// depends on dss_pkg for the strobe struct
module dss_line_store import dss_pkg::*; #(
   parameter int DEPTH  = DEF_MAX_SIDE,
   parameter int DATA_W = DEF_VALUE_BITS
) (
   input  logic                     clock,
   input  ls_ctl_type               ctl,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [DATA_W-1:0]        wr_a_data,
   input  logic [$clog2(DEPTH)-1:0] wr_b_addr,
   input  logic [DATA_W-1:0]        wr_b_data,
   output logic [DATA_W-1:0]        rd_a_data,
   output logic [DATA_W-1:0]        rd_b_data
);

   localparam int ADDR_W = $clog2(DEPTH);

   logic [DATA_W-1:0] mem_a_ff [DEPTH];
   logic [DATA_W-1:0] mem_b_ff [DEPTH];
   logic [DATA_W-1:0] rd_a_ff;
   logic [DATA_W-1:0] rd_b_ff;

   // read before write on the shared column address
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_a_ff <= mem_a_ff[addr];
         rd_b_ff <= mem_b_ff[addr];
      end
      if (ctl.wr_a_en) begin
         mem_a_ff[addr] <= wr_a_data;
      end
   end

   // b takes what a held one row earlier
   always_ff @(posedge clock) begin
      if (ctl.wr_b_en) begin
         mem_b_ff[wr_b_addr[ADDR_W-1:0]] <= wr_b_data;
      end
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

// ===== hdl/diffusion_stencil_sweep.sv =====
// top level of the five-point diffusion stencil sweep
// depends on dss_pkg, dss_req_if, dss_rsp_if, dss_line_store and assert_macros.svh
`include "assert_macros.svh"

// Grid values enter on req_chan in raster order (kind 0); flush items (kind 1)
// release the boundary results still owed at the end of a sweep. Every grid
// value from the second cell of the second row on gives one result on rsp_chan,
// for the cell grid_side+1 positions behind it; interior cells get
// u + r*(N+S+W+E-4u), rounded and saturated, boundary cells get zero. The
// last result of a sweep carries sweep_end.
// An item is accepted when valid and ready are both high. Throughput is one
// item per cycle while req_chan.ready is high. Stage 1 holds the item and the
// line store read taken at acceptance; the operand window, stencil sum and
// multiply follow, and the result register takes the rounded, saturated value.
// When the receiver stalls, results back up into the free pipeline stages
// and req_chan.ready falls only once all five stages hold items.
// The csr port writes grid_side (index 0, clamped to 3..MAX_SIDE, restarts
// the sweep) and diffusion_coeff (index 1, unsigned Q0.16 in 15 bits); write it only
// while the block is idle. Reset sets grid_side to 1024, the coefficient to
// 4096 and clears the raster position; the row buffers need no clearing.
module diffusion_stencil_sweep import dss_pkg::*; #(
   parameter int MAX_SIDE   = DEF_MAX_SIDE,
   parameter int VALUE_BITS = DEF_VALUE_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   dss_req_if.sink                req_chan,
   dss_rsp_if.source              rsp_chan
);

   localparam int SIDE_W = $clog2(MAX_SIDE + 1);
   localparam int POS_W  = $clog2(MAX_SIDE);
   localparam int PEND_W = $clog2(MAX_SIDE + 2);
   localparam int CMP_W  = (SIDE_W > GRID_SIDE_W) ? SIDE_W : GRID_SIDE_W;
   localparam int DW     = VALUE_BITS + 3;
   localparam int PW     = DW + COEFF_W + 1;
   localparam int RW     = DW + 1;

   // clamp the written side to the supported range
   function automatic logic [SIDE_W-1:0] clamp_side(input logic [GRID_SIDE_W-1:0] g);
      logic [CMP_W-1:0] gx;
      gx = CMP_W'(g);
      if (gx < CMP_W'(MIN_SIDE)) begin
         return SIDE_W'(MIN_SIDE);
      end else if (gx > CMP_W'(MAX_SIDE)) begin
         return SIDE_W'(MAX_SIDE);
      end else begin
         return SIDE_W'(gx);
      end
   endfunction

   // configuration and raster position
   logic [SIDE_W-1:0]  side_ff, side_in;
   logic [COEFF_W-1:0] coeff_ff, coeff_in;
   logic [POS_W-1:0]   row_ff, row_in;
   logic [POS_W-1:0]   col_ff, col_in;
   logic [PEND_W-1:0]  pend_ff, pend_in;

   // stage 1: accepted item and line store read data
   logic                         v1_ff, grid1_ff, res1_ff, int1_ff, end1_ff;
   logic signed [VALUE_BITS-1:0] cur1_ff;
   logic [POS_W-1:0]             col1_ff;
   logic signed [VALUE_BITS-1:0] rd_a, rd_b;

   // operand window of previous grid values
   logic signed [VALUE_BITS-1:0] a1_ff, a2_ff, b1_ff, u1_ff;

   // stage 2: stencil operands
   logic                         v2_ff, int2_ff, end2_ff;
   logic signed [VALUE_BITS-1:0] n2_ff, s2_ff, w2_ff, e2_ff, c2_ff;

   // stage 3: laplacian
   logic                         v3_ff, int3_ff, end3_ff;
   logic signed [DW-1:0]         d3_ff, d_in;
   logic signed [VALUE_BITS-1:0] c3_ff;

   // stage 4: scaled laplacian
   logic                         v4_ff, int4_ff, end4_ff;
   logic signed [PW-1:0]         p4_ff, prod_in;
   logic signed [VALUE_BITS-1:0] c4_ff;

   // result register
   logic                         out_v_ff, out_end_ff;
   logic signed [VALUE_BITS-1:0] out_val_ff;

   logic free_out, free4, free3, free2, free1;
   logic acc, pend_nz, flush_path, acc_grid, acc_zero;
   logic col_last, row_last, row_ge2, emit, interior, mv1;
   logic signed [COEFF_W:0]         coeff_sx;
   logic signed [PW-1:0]            rnd;
   logic signed [DW-1:0]            delta;
   logic signed [RW-1:0]            sum;
   logic [RW-VALUE_BITS:0]          sum_top;
   logic signed [VALUE_BITS-1:0]    sat;
   ls_ctl_type                      ls_ctl;

   // stage handshake: a stage takes an item when it is empty or drains
   assign free_out = !out_v_ff || rsp_chan.ready;
   assign free4    = !v4_ff || free_out;
   assign free3    = !v3_ff || free4;
   assign free2    = !v2_ff || free3;
   assign free1    = !v1_ff || free2;
   assign mv1      = v1_ff && free2;
   assign req_chan.ready = free1;

   // item decode at acceptance
   assign acc        = req_chan.valid && free1;
   assign pend_nz    = pend_ff != '0;
   assign flush_path = (req_chan.kind == KIND_FLUSH) || pend_nz;
   assign acc_grid   = acc && !flush_path;
   assign acc_zero   = acc && flush_path && pend_nz;
   assign col_last   = (SIDE_W'(col_ff) + SIDE_W'(1)) == side_ff;
   assign row_last   = (SIDE_W'(row_ff) + SIDE_W'(1)) == side_ff;
   assign row_ge2    = row_ff >= POS_W'(2);
   assign emit       = row_ge2 || ((row_ff == POS_W'(1)) && (col_ff != '0));
   assign interior   = row_ge2 && (col_ff >= POS_W'(2));

   // configuration writes and raster counters
   always_comb begin
      side_in  = side_ff;
      coeff_in = coeff_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      pend_in  = pend_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_GRID_SIDE: begin
               side_in = clamp_side(csr_wdata[GRID_SIDE_W-1:0]);
               row_in  = '0;
               col_in  = '0;
               pend_in = '0;
            end
            CSR_DIFF_COEFF: begin
               coeff_in = csr_wdata[COEFF_W-1:0];
            end
            default: begin
            end
         endcase
      end else if (acc_zero) begin
         pend_in = pend_ff - PEND_W'(1);
      end else if (acc_grid) begin
         if (col_last) begin
            col_in = '0;
            if (row_last) begin
               row_in  = '0;
               pend_in = PEND_W'(side_ff) + PEND_W'(1);
            end else begin
               row_in = row_ff + POS_W'(1);
            end
         end else begin
            col_in = col_ff + POS_W'(1);
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff  <= clamp_side(GRID_SIDE_RST);
         coeff_ff <= COEFF_RST;
         row_ff   <= '0;
         col_ff   <= '0;
         pend_ff  <= '0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         v4_ff    <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         side_ff  <= side_in;
         coeff_ff <= coeff_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         pend_ff  <= pend_in;
         if (free1) begin
            v1_ff <= acc_grid || acc_zero;
         end
         if (free2) begin
            v2_ff <= v1_ff && res1_ff;
         end
         if (free3) begin
            v3_ff <= v2_ff;
         end
         if (free4) begin
            v4_ff <= v3_ff;
         end
         if (free_out) begin
            out_v_ff <= v4_ff;
         end
      end
   end

   // row buffers: read and write the current column, pass a into b on leaving stage 1
   assign ls_ctl.rd_en   = acc_grid;
   assign ls_ctl.wr_a_en = acc_grid;
   assign ls_ctl.wr_b_en = mv1 && grid1_ff;

   dss_line_store #(
      .DEPTH  (MAX_SIDE),
      .DATA_W (VALUE_BITS)
   ) u_line_store (
      .clock     (clock),
      .ctl       (ls_ctl),
      .addr      (col_ff),
      .wr_a_data (req_chan.cell_value),
      .wr_b_addr (col1_ff),
      .wr_b_data (rd_a),
      .rd_a_data (rd_a),
      .rd_b_data (rd_b)
   );

   // laplacian and scaling
   assign d_in     = DW'(n2_ff) + DW'(s2_ff) + DW'(w2_ff) + DW'(e2_ff) - (DW'(c2_ff) <<< 2);
   assign coeff_sx = {1'b0, coeff_ff};
   assign prod_in  = d3_ff * coeff_sx;

   // round to nearest, add centre, saturate
   assign rnd     = p4_ff + PW'(ROUND_HALF);
   assign delta   = rnd[PW-1:FRAC_BITS];
   assign sum     = RW'(c4_ff) + RW'(delta);
   assign sum_top = sum[RW-1:VALUE_BITS-1];
   always_comb begin
      if ((&sum_top) || !(|sum_top)) begin
         sat = sum[VALUE_BITS-1:0];
      end else if (sum[RW-1]) begin
         sat = {1'b1, {(VALUE_BITS-1){1'b0}}};
      end else begin
         sat = {1'b0, {(VALUE_BITS-1){1'b1}}};
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      if (free1) begin
         grid1_ff <= acc_grid;
         res1_ff  <= acc_zero || emit;
         int1_ff  <= acc_grid && interior;
         end1_ff  <= acc_zero && (pend_ff == PEND_W'(1));
         cur1_ff  <= req_chan.cell_value;
         col1_ff  <= col_ff;
      end
      // window shifts once per grid value
      if (mv1 && grid1_ff) begin
         a1_ff <= rd_a;
         a2_ff <= a1_ff;
         b1_ff <= rd_b;
         u1_ff <= cur1_ff;
      end
      if (free2) begin
         n2_ff   <= b1_ff;
         s2_ff   <= u1_ff;
         w2_ff   <= a2_ff;
         c2_ff   <= a1_ff;
         e2_ff   <= rd_a;
         int2_ff <= int1_ff;
         end2_ff <= end1_ff;
      end
      if (free3) begin
         d3_ff   <= d_in;
         c3_ff   <= c2_ff;
         int3_ff <= int2_ff;
         end3_ff <= end2_ff;
      end
      if (free4) begin
         p4_ff   <= prod_in;
         c4_ff   <= c3_ff;
         int4_ff <= int3_ff;
         end4_ff <= end3_ff;
      end
      if (free_out) begin
         out_val_ff <= int4_ff ? sat : '0;
         out_end_ff <= end4_ff;
      end
   end

   assign rsp_chan.valid     = out_v_ff;
   assign rsp_chan.new_value = out_val_ff;
   assign rsp_chan.sweep_end = out_end_ff;

   // checks
   `DSS_ASSERT_IMP(a_pos_in_grid, clock, reset, 1'b1,
      (SIDE_W'(col_ff) < side_ff) && (SIDE_W'(row_ff) < side_ff),
      "raster position outside the grid")
   `DSS_ASSERT_IMP(a_pend_bound, clock, reset, 1'b1,
      pend_ff <= (PEND_W'(side_ff) + PEND_W'(1)), "more results owed than a row and a cell")
   `DSS_ASSERT_NXT(a_sweep_wrap, clock, reset,
      acc_grid && col_last && row_last && !csr_wr_en,
      pend_ff == (PEND_W'(side_ff) + PEND_W'(1)), "last cell did not arm the flush count")
   `DSS_ASSERT_IMP(a_ready_on_stall, clock, reset, !req_chan.ready,
      v1_ff && v2_ff && v3_ff && v4_ff && out_v_ff && !rsp_chan.ready,
      "input held off with room in the pipeline")
   `DSS_ASSERT_IMP(a_end_is_zero, clock, reset, rsp_chan.valid && rsp_chan.sweep_end,
      rsp_chan.new_value == '0, "final boundary item is not zero")

endmodule
